// File: hdl/swps_pkg.sv
// Shared widths, command/status structs and helper functions for the waypoint path selector.
package swps_pkg;

   localparam int MAX_PATHS  = 256;
   localparam int COORD_BITS = 16;

   localparam int DIFF_W = COORD_BITS;                 // |a - b| of two signed coordinates
   localparam int SQ_W   = 2 * DIFF_W;                 // one squared difference
   localparam int ROOT_W = DIFF_W + 1;                 // root of the sum of two squares
   localparam int RAD_W  = 2 * ROOT_W;                 // radicand, two bits per root digit
   localparam int REM_W  = ROOT_W + 2;                 // partial remainder
   localparam int CNT_W  = $clog2(ROOT_W);             // root digit counter
   localparam int LEN_W  = 32;                         // path length field
   localparam int IDX_W  = 8;                          // path index fields
   localparam int PCNT_W = (MAX_PATHS > 2) ? $clog2(MAX_PATHS) : 1;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Datapath commands, one per controller state.
   typedef struct packed {
      logic load;       // take the waypoint, form the differences
      logic sq_x;       // square dx
      logic sq_y;       // square dy, add, seed the root unit
      logic root_step;  // one root digit
      logic accum;      // add the segment to the running length
      logic emit;       // close the path and load the result register
   } cmd_type;

   typedef struct packed {
      logic first_point;
      logic path_end;
   } sts_type;

   // Saturating add of a segment length to the running path length.
   function automatic logic [LEN_W-1:0] len_add(logic [LEN_W-1:0] run,
                                                 logic [ROOT_W-1:0] seg);
      logic [LEN_W+ROOT_W:0] s;
      s = (LEN_W + ROOT_W + 1)'(run) + (LEN_W + ROOT_W + 1)'(seg);
      if (s > (LEN_W + ROOT_W + 1)'(LEN_MAX)) begin
         return LEN_MAX;
      end
      return s[LEN_W-1:0];
   endfunction

   // Low index bits of the path counter.
   function automatic logic [IDX_W-1:0] idx_out(logic [PCNT_W-1:0] v);
      logic [PCNT_W+IDX_W-1:0] t;
      t = (PCNT_W + IDX_W)'(v);
      return t[IDX_W-1:0];
   endfunction

endpackage

// File: hdl/swps_req_if.sv
// Waypoint input channel: valid/ready handshake with the waypoint fields.
interface swps_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [swps_pkg::COORD_BITS-1:0] x_pos;
   logic signed [swps_pkg::COORD_BITS-1:0] y_pos;
   logic                               path_end;
   logic                               set_end;

   modport source (output valid, x_pos, y_pos, path_end, set_end, input ready);
   modport sink   (input valid, x_pos, y_pos, path_end, set_end, output ready);
endinterface

// File: hdl/swps_rsp_if.sv
// Result channel: valid/ready handshake with the per-path result fields.
interface swps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swps_pkg::IDX_W-1:0]    path_number;
   logic [swps_pkg::LEN_W-1:0]    path_length;
   logic [swps_pkg::IDX_W-1:0]    best_number;
   logic [swps_pkg::LEN_W-1:0]    best_length;
   logic                          set_done;

   modport source (output valid, path_number, path_length, best_number, best_length,
                   set_done, input ready);
   modport sink   (input valid, path_number, path_length, best_number, best_length,
                   set_done, output ready);
endinterface

// File: hdl/swps_ctrl.sv
// Sequencer for the waypoint path selector: state machine, root digit counter, result valid.
module swps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  swps_pkg::sts_type sts,
   output swps_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SQX,
      SQY,
      ROOT,
      ACC,
      FIN
   } state_type;

   state_type                   state_ff;
   logic [swps_pkg::CNT_W-1:0]  cnt_ff;
   logic                        rsp_valid_ff;
   logic                        accept;
   logic                        out_free;
   logic                        root_last;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign root_last = (cnt_ff == swps_pkg::CNT_W'(swps_pkg::ROOT_W - 1));
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.sq_x      = (state_ff == SQX);
      cmd.sq_y      = (state_ff == SQY);
      cmd.root_step = (state_ff == ROOT);
      cmd.accum     = (state_ff == ACC);
      cmd.emit      = (state_ff == FIN) && sts.path_end && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= sts.first_point ? FIN : SQX;
               end
            end
            SQX: begin
               state_ff <= SQY;
            end
            SQY: begin
               cnt_ff   <= '0;
               state_ff <= ROOT;
            end
            ROOT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (root_last) begin
                  state_ff <= ACC;
               end
            end
            ACC: begin
               state_ff <= FIN;
            end
            FIN: begin
               if (!sts.path_end || out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // Never overwrite a result that is still waiting.
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   // A point that follows the first one of a path goes through the squarer.
   a_seg_path: assert property (@(posedge clock) disable iff (reset)
      (accept && !sts.first_point) |=> (state_ff == SQX))
      else $error("segment skipped for a non-first point");

   // The root unit runs exactly ROOT_W digits.
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ROOT) |-> (cnt_ff <= swps_pkg::CNT_W'(swps_pkg::ROOT_W - 1)))
      else $error("root digit counter overran");

endmodule

// File: hdl/swps_dpath.sv
// Datapath for the waypoint path selector: differences, shared squarer, root unit, lengths.
module swps_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swps_pkg::cmd_type                     cmd,
   output swps_pkg::sts_type                     sts,
   input  logic signed [swps_pkg::COORD_BITS-1:0] x_pos,
   input  logic signed [swps_pkg::COORD_BITS-1:0] y_pos,
   input  logic                                  path_end,
   input  logic                                  set_end,
   output logic [swps_pkg::IDX_W-1:0]            path_number,
   output logic [swps_pkg::LEN_W-1:0]            path_length,
   output logic [swps_pkg::IDX_W-1:0]            best_number,
   output logic [swps_pkg::LEN_W-1:0]            best_length,
   output logic                                  set_done
);

   localparam int CW = swps_pkg::COORD_BITS;

   // Path state
   logic [CW-1:0]                    prev_x_ff;
   logic [CW-1:0]                    prev_y_ff;
   logic                             first_ff;
   logic                             pend_ff;
   logic                             send_ff;
   logic [swps_pkg::LEN_W-1:0]       run_ff;
   logic [swps_pkg::LEN_W-1:0]       min_ff;
   logic [swps_pkg::PCNT_W-1:0]      best_ff;
   logic [swps_pkg::PCNT_W-1:0]      count_ff;

   // Segment pipeline
   logic [swps_pkg::DIFF_W-1:0]      dx_ff;
   logic [swps_pkg::DIFF_W-1:0]      dy_ff;
   logic [swps_pkg::SQ_W-1:0]        sq_ff;
   logic [swps_pkg::RAD_W-1:0]       rad_ff;
   logic [swps_pkg::REM_W-1:0]       rem_ff;
   logic [swps_pkg::ROOT_W-1:0]      root_ff;

   // Result register
   logic [swps_pkg::IDX_W-1:0]       path_number_ff;
   logic [swps_pkg::LEN_W-1:0]       path_length_ff;
   logic [swps_pkg::IDX_W-1:0]       best_number_ff;
   logic [swps_pkg::LEN_W-1:0]       best_length_ff;
   logic                             set_done_ff;

   logic [swps_pkg::DIFF_W-1:0]      dx_in;
   logic [swps_pkg::DIFF_W-1:0]      dy_in;
   logic [swps_pkg::DIFF_W-1:0]      mul_a;
   logic [swps_pkg::SQ_W-1:0]        prod;
   logic [swps_pkg::REM_W-1:0]       rem_sh;
   logic [swps_pkg::REM_W-1:0]       trial;
   logic                             digit;
   logic                             better;
   logic [swps_pkg::LEN_W-1:0]       min_in;
   logic [swps_pkg::PCNT_W-1:0]      best_in;

   function automatic logic [swps_pkg::DIFF_W-1:0] abs_diff(logic [CW-1:0] a,
                                                            logic [CW-1:0] b);
      logic signed [CW:0] d;
      d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
      if (d[CW]) begin
         d = -d;
      end
      return d[swps_pkg::DIFF_W-1:0];
   endfunction

   assign dx_in = abs_diff(x_pos, prev_x_ff);
   assign dy_in = abs_diff(y_pos, prev_y_ff);

   // One squarer, shared between dx and dy.
   assign mul_a = cmd.sq_y ? dy_ff : dx_ff;
   assign prod  = swps_pkg::SQ_W'(mul_a) * swps_pkg::SQ_W'(mul_a);

   // Restoring square root, one digit a cycle.
   assign rem_sh = {rem_ff[swps_pkg::ROOT_W-1:0],
                    rad_ff[swps_pkg::RAD_W-1:swps_pkg::RAD_W-2]};
   assign trial  = swps_pkg::REM_W'({root_ff[swps_pkg::ROOT_W-2:0], 2'b01});
   assign digit  = (rem_sh >= trial);

   assign better  = (run_ff < min_ff);
   assign min_in  = better ? run_ff : min_ff;
   assign best_in = better ? count_ff : best_ff;

   assign sts.first_point = first_ff;
   assign sts.path_end    = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         first_ff  <= 1'b1;
         pend_ff   <= 1'b0;
         send_ff   <= 1'b0;
         run_ff    <= '0;
         min_ff    <= swps_pkg::LEN_MAX;
         best_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd.load) begin
            prev_x_ff <= x_pos;
            prev_y_ff <= y_pos;
            first_ff  <= 1'b0;
            pend_ff   <= path_end;
            send_ff   <= set_end;
         end
         if (cmd.accum) begin
            run_ff <= swps_pkg::len_add(run_ff, root_ff);
         end
         if (cmd.emit) begin
            first_ff <= 1'b1;
            run_ff   <= '0;
            if (send_ff) begin
               min_ff   <= swps_pkg::LEN_MAX;
               best_ff  <= '0;
               count_ff <= '0;
            end else begin
               min_ff  <= min_in;
               best_ff <= best_in;
               if (count_ff == swps_pkg::PCNT_W'(swps_pkg::MAX_PATHS - 1)) begin
                  count_ff <= '0;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.sq_x) begin
         sq_ff <= prod;
      end
      if (cmd.sq_y) begin
         rad_ff  <= swps_pkg::RAD_W'(sq_ff) + swps_pkg::RAD_W'(prod);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= digit ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[swps_pkg::ROOT_W-2:0], digit};
      end
      if (cmd.emit) begin
         path_number_ff <= swps_pkg::idx_out(count_ff);
         path_length_ff <= run_ff;
         best_number_ff <= swps_pkg::idx_out(best_in);
         best_length_ff <= min_in;
         set_done_ff    <= send_ff;
      end
   end

   assign path_number = path_number_ff;
   assign path_length = path_length_ff;
   assign best_number = best_number_ff;
   assign best_length = best_length_ff;
   assign set_done    = set_done_ff;

   // The best length reported never exceeds the path just closed.
   a_best_le_path: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (best_length_ff <= path_length_ff))
      else $error("best length above completed path length");

   // Closing a path restarts the running length and the first-point flag.
   a_emit_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (run_ff == '0) && first_ff)
      else $error("path state not restarted after close");

   // Closing a set clears the search.
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && send_ff) |=> (min_ff == swps_pkg::LEN_MAX) && (count_ff == '0))
      else $error("search not cleared at set end");

endmodule

// File: hdl/shortest_waypoint_path_select.sv
// Top level of the shortest waypoint path selector: channels, sequencer and datapath.
//
//   channel   direction  transfer                    fields
//   req_chan  in         one waypoint                x_pos, y_pos, path_end, set_end
//   rsp_chan  out        one closed-path result      path_number, path_length,
//                                                     best_number, best_length, set_done
//
// A waypoint that opens a path goes from load straight to the close step; any later
// waypoint goes through load, squaring of dx and then dy on the one shared multiplier,
// one digit step per root bit in the restoring square root, accumulate and close.
// req_chan.ready is high only while the sequencer is idle; the result register frees the
// input side, so a new waypoint is taken while an earlier result waits on rsp_chan.
// A path close that finds the result register still held waits in its close step.
// Reset is synchronous, active high; it clears the path state, the search and rsp valid.
module shortest_waypoint_path_select (
   input  logic       clock,
   input  logic       reset,
   swps_req_if.sink   req_chan,
   swps_rsp_if.source rsp_chan
);

   swps_pkg::cmd_type cmd;
   swps_pkg::sts_type sts;

   // Sequencer: decides when to take a waypoint and when to release a result.
   swps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: segment length, running length, best-path search, result register.
   swps_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .x_pos       (req_chan.x_pos),
      .y_pos       (req_chan.y_pos),
      .path_end    (req_chan.path_end),
      .set_end     (req_chan.set_end),
      .path_number (rsp_chan.path_number),
      .path_length (rsp_chan.path_length),
      .best_number (rsp_chan.best_number),
      .best_length (rsp_chan.best_length),
      .set_done    (rsp_chan.set_done)
   );

endmodule

// File: tb/sv/tb_shortest_waypoint_path_select.sv
// Self-checking testbench for the shortest waypoint path selector.
module tb_shortest_waypoint_path_select;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [swps_pkg::COORD_BITS-1:0] coord_type;

   // One closed-path result as it leaves the block.
   typedef struct packed {
      logic [swps_pkg::IDX_W-1:0] path_number;
      logic [swps_pkg::LEN_W-1:0] path_length;
      logic [swps_pkg::IDX_W-1:0] best_number;
      logic [swps_pkg::LEN_W-1:0] best_length;
      logic                       set_done;
   } path_result_type;

   // Shape of the coordinate walk inside one random path.
   typedef enum {STEP_ANY, STEP_FINE, STEP_COARSE, STEP_CORNER} step_style_type;

   // Receiver stall patterns.
   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   localparam coord_type   COORD_MIN      = coord_type'(1 << (swps_pkg::COORD_BITS - 1));
   localparam coord_type   COORD_MAX      = ~COORD_MIN;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned RANDOM_ITEMS   = 1000;
   localparam int unsigned HOLD_OFF_CYCLES = 3000;
   localparam int unsigned WRAP_PATHS     = swps_pkg::MAX_PATHS + 6;
   localparam int unsigned DRAIN_CYCLES   = 60;
   localparam longint      RUN_LIMIT_NS   = 50_000_000;

   // Path length tracker and store of pending path results.
   class path_length_board;
      path_result_type            expected_q[$];
      coord_type                  last_x, last_y;
      bit                         at_path_start;
      logic [swps_pkg::LEN_W-1:0] path_sum, shortest_len;
      int unsigned                path_index, shortest_index;
      int unsigned                mismatches;

      function new();
         last_x         = '0;
         last_y         = '0;
         at_path_start  = 1'b1;
         path_sum       = '0;
         shortest_len   = swps_pkg::LEN_MAX;
         path_index     = 0;
         shortest_index = 0;
         mismatches     = 0;
      endfunction

      // Advance the path state by one accepted waypoint.
      function void note_waypoint(coord_type x, coord_type y, bit pend, bit send);
         int                         dx, dy;
         logic [71:0]                radicand, root, trial;
         logic [swps_pkg::LEN_W-1:0] seg;
         logic [swps_pkg::LEN_W:0]   total;
         path_result_type            r;
         if (!at_path_start) begin
            dx = int'(x) - int'(last_x);
            dy = int'(y) - int'(last_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            radicand = 72'(dx) * 72'(dx) + 72'(dy) * 72'(dy);
            // truncated root, one bit at a time from the top
            root = '0;
            for (int b = 33; b >= 0; b--) begin
               trial = root | (72'(1) << b);
               if (trial * trial <= radicand) root = trial;
            end
            seg   = (root > 72'(swps_pkg::LEN_MAX)) ? swps_pkg::LEN_MAX
                                                     : root[swps_pkg::LEN_W-1:0];
            total = (swps_pkg::LEN_W + 1)'(path_sum) + (swps_pkg::LEN_W + 1)'(seg);
            path_sum = total[swps_pkg::LEN_W] ? swps_pkg::LEN_MAX
                                              : total[swps_pkg::LEN_W-1:0];
         end
         last_x        = x;
         last_y        = y;
         at_path_start = 1'b0;
         if (!pend) return;

         // strictly shorter only: the earlier path keeps a tie
         if (path_sum < shortest_len) begin
            shortest_len   = path_sum;
            shortest_index = path_index;
         end
         r.path_number = swps_pkg::IDX_W'(path_index);
         r.path_length = path_sum;
         r.best_number = swps_pkg::IDX_W'(shortest_index);
         r.best_length = shortest_len;
         r.set_done    = send;
         expected_q    = {expected_q, r};

         at_path_start = 1'b1;
         path_sum      = '0;
         if (send) begin
            shortest_len   = swps_pkg::LEN_MAX;
            shortest_index = 0;
            path_index     = 0;
         end else begin
            path_index = (path_index + 1 >= swps_pkg::MAX_PATHS) ? 0 : path_index + 1;
         end
      endfunction

      // Compare one result transfer with the oldest pending result.
      function void check_result(path_result_type got);
         path_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] result with none pending: path %0d len %h", $time,
                        got.path_number, got.path_length);
            return;
         end
         want = expected_q.pop_front();
         if (got.path_number !== want.path_number || got.path_length !== want.path_length ||
             got.best_number !== want.best_number || got.best_length !== want.best_length ||
             got.set_done !== want.set_done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"[%0t] result mismatch (expected/actual): path %0d/%0d len %h/%h",
                         " best %0d/%0d best_len %h/%h done %0b/%0b"}, $time,
                        want.path_number, got.path_number, want.path_length, got.path_length,
                        want.best_number, got.best_number, want.best_length, got.best_length,
                        want.set_done, got.set_done);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   swps_req_if req_chan();
   swps_rsp_if rsp_chan();

   shortest_waypoint_path_select dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   path_length_board board = new();

   // Sender pacing: bursts of back-to-back offers separated by random gaps.
   int unsigned burst_left  = 0;
   bit          sender_idle = 1'b1;
   int unsigned sent_items  = 0;
   // Raised once by the stimulus; the receiver then holds off on its own count.
   bit          hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: generous compared to the slowest legal run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one waypoint and hold it until the block takes it.
   task automatic send_waypoint(input coord_type x, input coord_type y, input bit pend,
                                input bit send);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_idle ? $urandom_range(0, 40) : 0;
         // drop valid only when a real gap follows, never lower-and-raise in one step
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.x_pos    <= x;
      req_chan.y_pos    <= y;
      req_chan.path_end <= pend;
      req_chan.set_end  <= send;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      board.note_waypoint(x, y, pend, send);
      sent_items++;
   endtask

   function automatic coord_type pick_corner();
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return coord_type'(0);
         3:       return coord_type'(-1);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // One complete candidate set: random path lengths and coordinate walks; set_end
   // shows up as noise on inner points and closes the set on the last path.
   task automatic send_random_set(input int unsigned path_total);
      int unsigned    points;
      step_style_type style;
      coord_type      x, y;
      bit             last;
      for (int unsigned p = 0; p < path_total; p++) begin
         points = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 7);
         style  = step_style_type'($urandom_range(0, 3));
         x      = coord_type'($urandom);
         y      = coord_type'($urandom);
         for (int unsigned i = 0; i < points; i++) begin
            if (i != 0 && $urandom_range(0, 15) == 0) begin
               // hold the point: zero-length segment
            end else begin
               case (style)
                  STEP_FINE: begin
                     x = x + coord_type'($urandom_range(0, 128)) - coord_type'(64);
                     y = y + coord_type'($urandom_range(0, 128)) - coord_type'(64);
                  end
                  STEP_COARSE: begin
                     x = x + coord_type'($urandom_range(0, 8192)) - coord_type'(4096);
                     y = y + coord_type'($urandom_range(0, 8192)) - coord_type'(4096);
                  end
                  STEP_CORNER: begin
                     x = pick_corner();
                     y = pick_corner();
                  end
                  default: begin
                     x = coord_type'($urandom);
                     y = coord_type'($urandom);
                  end
               endcase
            end
            last = (i == points - 1);
            send_waypoint(x, y, last,
                          last ? (p == path_total - 1) : ($urandom_range(0, 7) == 0));
         end
      end
   endtask

   // Receiver: switch among stall patterns at random intervals; on request hold
   // ready low for a long stretch so results back up and the input side stalls.
   initial begin : result_receiver
      ready_mode_type mode;
      int unsigned    mode_left, tick;
      mode      = READY_ALWAYS;
      mode_left = 0;
      tick      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            READY_HALF:     rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE:   rsp_chan.ready <= ($urandom_range(0, 9) == 0);
            READY_PERIODIC: rsp_chan.ready <= ((tick % 7) < 3);
            default:        rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   // Check every result transfer; values are sampled as they stood before the edge.
   always @(posedge clock) begin : result_monitor
      path_result_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.path_number = rsp_chan.path_number;
         got.path_length = rsp_chan.path_length;
         got.best_number = rsp_chan.best_number;
         got.best_length = rsp_chan.best_length;
         got.set_done    = rsp_chan.set_done;
         board.check_result(got);
      end
   end

   initial begin : stimulus
      int unsigned start;
      bit          pressed;
      pressed = 1'b0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.x_pos    <= '0;
      req_chan.y_pos    <= '0;
      req_chan.path_end <= 1'b0;
      req_chan.set_end  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed set: path 0 is a 3-4-5 triangle scaled by 16 (length 80).
      send_waypoint(coord_type'(0), coord_type'(0), 1'b0, 1'b0);
      send_waypoint(coord_type'(48), coord_type'(64), 1'b1, 1'b0);
      // Path 1: same length, set_end on an inner point must be ignored; tie keeps path 0.
      send_waypoint(coord_type'(16), coord_type'(0), 1'b0, 1'b1);
      send_waypoint(coord_type'(-32), coord_type'(-64), 1'b1, 1'b0);
      // Path 2: a single point closes with length 0 and becomes the best.
      send_waypoint(COORD_MIN, COORD_MAX, 1'b1, 1'b0);
      // Path 3: longest possible segment, corner to corner.
      send_waypoint(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
      send_waypoint(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
      // Path 4: the other diagonal, a repeated point, then small odd steps.
      send_waypoint(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
      send_waypoint(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      send_waypoint(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      send_waypoint(coord_type'(-1), coord_type'(-1), 1'b0, 1'b0);
      send_waypoint(coord_type'(0), coord_type'(0), 1'b0, 1'b0);
      send_waypoint(coord_type'(1), coord_type'(0), 1'b1, 1'b0);
      // Path 5: a single point at the origin ties path 2 and closes the set.
      send_waypoint(coord_type'(0), coord_type'(0), 1'b1, 1'b1);
      // A set of one single-point path, then a set of one short path.
      send_waypoint(coord_type'(5), coord_type'(-5), 1'b1, 1'b1);
      send_waypoint(coord_type'(1), coord_type'(1), 1'b0, 1'b0);
      send_waypoint(coord_type'(2), coord_type'(2), 1'b1, 1'b1);

      // Random sets. Run a stretch with no sender gaps, and once in the second half
      // ask the receiver to hold off while offers continue.
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         sender_idle = (sent_items - start < 300) || (sent_items - start > 500);
         if (!pressed && sent_items - start > RANDOM_ITEMS / 2) begin
            hold_off_req = 1'b1;
            pressed      = 1'b1;
         end
         send_random_set(($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(1, 6));
      end
      sender_idle = 1'b1;

      // Path index wrap: more paths than the counter holds in one set. Paths up to the
      // second-to-last index are two random points; the last index is a single point
      // and takes the best; the wrapped paths after it only tie.
      for (int unsigned p = 0; p < WRAP_PATHS; p++) begin
         if (p < swps_pkg::MAX_PATHS - 1) begin
            send_waypoint(coord_type'($urandom), coord_type'($urandom), 1'b0, 1'b0);
            send_waypoint(coord_type'($urandom), coord_type'($urandom), 1'b1, 1'b0);
         end else begin
            send_waypoint(coord_type'($urandom), coord_type'($urandom), 1'b1,
                          p == WRAP_PATHS - 1);
         end
      end

      // Drain: wait for every pending result, then keep watching for stray results.
      req_chan.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: shortest_waypoint_path_select.f
hdl/swps_pkg.sv
hdl/swps_req_if.sv
hdl/swps_rsp_if.sv
hdl/swps_ctrl.sv
hdl/swps_dpath.sv
hdl/shortest_waypoint_path_select.sv
tb/sv/tb_shortest_waypoint_path_select.sv
